// ----- hdl/detection_row_topk_decode_assert.svh -----
// ----------------------------------------------------------------------------
// detection_row_topk_decode assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DETECTION_ROW_TOPK_DECODE_ASSERT_SVH
`define DETECTION_ROW_TOPK_DECODE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define DTK_ASSERT_IMPLY(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define DTK_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- hdl/dtk_pkg.sv -----
// ----------------------------------------------------------------------------
// dtk_pkg
// Shared types and constants of the detection row top-k decoder.
// ----------------------------------------------------------------------------
package dtk_pkg;

   // Row layout: four box values, then objectness, then class columns
   localparam int NUM_BOX = 4;

   // Register indexes of the configuration port, byte address over four
   localparam logic [2:0] REG_CONF_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_X_SCALE        = 3'd1;
   localparam logic [2:0] REG_Y_SCALE        = 3'd2;
   localparam logic [2:0] REG_FRAME_WIDTH    = 3'd3;
   localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd4;

   // One ranked entry as held in a cell of the ranking chain
   typedef struct packed {
      logic               valid;
      logic [6:0]         class_id;
      logic signed [31:0] score;
   } entry_type;

   // What a cell hands to its right neighbor
   typedef struct packed {
      entry_type entry;
      logic      beats;   // held entry ranks at or above the incoming one
   } cell_link_type;

   // One result beat, last field in the lowest bits
   typedef struct packed {
      logic signed [15:0] box_height;
      logic signed [15:0] box_width;
      logic signed [15:0] box_top;
      logic signed [15:0] box_left;
      logic signed [31:0] class_score;
      logic [6:0]         class_id;
      logic [2:0]         rank;
   } result_type;

endpackage

// ----- hdl/dtk_cell.sv -----
// ----------------------------------------------------------------------------
// dtk_cell
// One slot of the ranking chain: holds, takes the new entry, or takes its
// left neighbor's entry when the new one lands further left.
// ----------------------------------------------------------------------------
module dtk_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ins,        // new entry offered this cycle
   input  logic                   clr,        // end of row: empty the slot
   input  dtk_pkg::entry_type     new_entry,
   input  dtk_pkg::cell_link_type prev_link,
   output dtk_pkg::cell_link_type link_out,
   output dtk_pkg::entry_type     next_entry  // content after this insert
);
   import dtk_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      beats;

   // Ties keep the earlier class ahead
   assign beats = entry_ff.valid &&
                  ($signed(entry_ff.score) >= $signed(new_entry.score));

   // Hold, take the new entry, or shift in the neighbor's entry
   always_comb begin
      entry_in = entry_ff;
      if (ins && !beats) begin
         if (prev_link.beats) begin
            entry_in = new_entry;
         end else begin
            entry_in = prev_link.entry;
         end
      end
   end

   // Empty the slot at row end, else advance
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (clr) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign link_out.entry = entry_ff;
   assign link_out.beats = beats;
   assign next_entry     = entry_in;

endmodule

// ----- hdl/dtk_emit.sv -----
// ----------------------------------------------------------------------------
// dtk_emit
// Result unit: snapshots a finished row, decodes its box with one shared
// multiplier in turns, then sends the ranked entries one per beat.
// ----------------------------------------------------------------------------
module dtk_emit #(
   parameter int TOP_K = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  dtk_pkg::entry_type        load_entries [TOP_K],
   input  logic signed [31:0]        load_raw [dtk_pkg::NUM_BOX],
   input  logic [21:0]               x_scale,
   input  logic [21:0]               y_scale,
   input  logic [14:0]               frame_width,
   input  logic [14:0]               frame_height,
   output logic                      busy,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_last,
   output dtk_pkg::result_type       rsp_result
);
   import dtk_pkg::*;

   localparam int CNT_W = $clog2(TOP_K + 1);
   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_EDGE = 4'b0100,
      ST_SEND = 4'b1000
   } emit_state_type;

   emit_state_type     state_ff, state_in;
   logic [1:0]         step_ff;
   logic [CNT_W-1:0]   remain_ff;
   logic [2:0]         rank_ff;
   entry_type          buf_ff [TOP_K];
   logic signed [31:0] raw_ff [NUM_BOX];
   logic signed [38:0] coord_ff [NUM_BOX];
   logic signed [15:0] left_ff, top_ff, width_ff, height_ff;

   logic               use_scale;
   logic [21:0]        scale_sel;
   logic signed [54:0] prod;
   logic signed [54:0] prod_bias;
   logic signed [54:0] prod_adj;
   logic signed [38:0] coord_in;
   logic signed [38:0] half_w, half_h;
   logic [TOP_K-1:0]   load_valid;
   logic               send_beat;

   function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
      logic signed [15:0] r;
      if (v > 40'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -40'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Pick pixel scale when any raw coordinate lies above 1.0
   assign use_scale = (raw_ff[0] > ONE_Q16) || (raw_ff[1] > ONE_Q16) ||
                      (raw_ff[2] > ONE_Q16) || (raw_ff[3] > ONE_Q16);

   // Odd steps are vertical values
   always_comb begin
      if (use_scale) begin
         scale_sel = step_ff[0] ? y_scale : x_scale;
      end else begin
         scale_sel = step_ff[0] ? {7'b0, frame_height} : {7'b0, frame_width};
      end
   end

   // Shared multiplier, product truncated toward zero
   assign prod      = raw_ff[step_ff] * $signed({1'b0, scale_sel});
   assign prod_bias = use_scale ? $signed({23'b0, {32{prod[54]}}})
                                : $signed({39'b0, {16{prod[54]}}});
   assign prod_adj  = prod + prod_bias;
   assign coord_in  = use_scale ? {{16{prod_adj[54]}}, prod_adj[54:32]}
                                : prod_adj[54:16];

   // Halve width and height toward zero
   assign half_w = (coord_ff[2] + $signed({38'b0, coord_ff[2][38]})) >>> 1;
   assign half_h = (coord_ff[3] + $signed({38'b0, coord_ff[3][38]})) >>> 1;

   always_comb begin
      for (int i = 0; i < TOP_K; i++) begin
         load_valid[i] = load_entries[i].valid;
      end
   end

   assign send_beat = (state_ff == ST_SEND) && rsp_ready;

   // Sequence: multiply four coordinates, form edges, send entries
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (step_ff == 2'd3) begin
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready && (remain_ff == CNT_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         remain_ff <= '0;
         rank_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_IDLE) && load) begin
            step_ff   <= '0;
            rank_ff   <= '0;
            remain_ff <= CNT_W'($countones(load_valid));
         end else if (state_ff == ST_MUL) begin
            step_ff <= step_ff + 2'd1;
         end else if (send_beat) begin
            rank_ff   <= rank_ff + 3'd1;
            remain_ff <= remain_ff - CNT_W'(1);
         end
      end
   end

   // Payload: snapshot, coordinates, edges, and the shifting entry buffer
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && load) begin
         for (int i = 0; i < TOP_K; i++) begin
            buf_ff[i] <= load_entries[i];
         end
         for (int i = 0; i < NUM_BOX; i++) begin
            raw_ff[i] <= load_raw[i];
         end
      end else if (send_beat) begin
         for (int i = 0; i < TOP_K - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
      end
      if (state_ff == ST_MUL) begin
         coord_ff[step_ff] <= coord_in;
      end
      if (state_ff == ST_EDGE) begin
         left_ff   <= sat16(40'(coord_ff[0]) - 40'(half_w));
         top_ff    <= sat16(40'(coord_ff[1]) - 40'(half_h));
         width_ff  <= sat16(40'(coord_ff[2]));
         height_ff <= sat16(40'(coord_ff[3]));
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);
   assign rsp_last  = (remain_ff == CNT_W'(1));

   assign rsp_result.rank        = rank_ff;
   assign rsp_result.class_id    = buf_ff[0].class_id;
   assign rsp_result.class_score = buf_ff[0].score;
   assign rsp_result.box_left    = left_ff;
   assign rsp_result.box_top     = top_ff;
   assign rsp_result.box_width   = width_ff;
   assign rsp_result.box_height  = height_ff;

endmodule

// ----- hdl/detection_row_topk_decode.sv -----
// ----------------------------------------------------------------------------
// detection_row_topk_decode
// Ranks the class scores of a detector output row in a chain of cells and
// sends the best TOP_K classes with the decoded box at row end.
// ----------------------------------------------------------------------------
//  channel  | port group | beat carries
//  ---------+------------+-------------------------------------------------
//  input    | req_*      | element_value in tdata, row_end in tlast
//  result   | rsp_*      | rank, class_id, class_score, box fields in tdata,
//           |            | last_of_row in tlast
//  config   | csr_*      | conf_threshold, x_scale, y_scale, frame_width,
//           |            | frame_height at 0x00, 0x04, 0x08, 0x0c, 0x10
//
//  One row element is taken each cycle while req_tready is high; a class
//  score is multiplied by objectness on entry, registered, and then ranked
//  in the cell chain. The box is formed by one multiplier, coordinate by
//  coordinate; the first result of a row leaves once its edges are formed,
//  the others one per cycle while rsp_tready is high. req_tready drops
//  while a row end waits in the ranking stage and the previous row's results
//  still drain. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "detection_row_topk_decode_assert.svh"

module detection_row_topk_decode #(
   parameter int TOP_K       = 5,
   parameter int MAX_CLASSES = 128
) (
   input  logic          clock,
   input  logic          reset,
   // input stream
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // [31:0] element_value
   input  logic          req_tlast,   // row_end
   // result stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,   // [2:0] rank, [9:3] class_id,
                                      // [41:10] class_score, [57:42] box_left,
                                      // [73:58] box_top, [89:74] box_width,
                                      // [105:90] box_height, rest zero
   output logic          rsp_tlast,   // last_of_row
   // configuration
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [4:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   import dtk_pkg::*;

   localparam int FIRST_CLASS = NUM_BOX + 1;
   localparam int IDX_W       = $clog2(FIRST_CLASS + MAX_CLASSES + 1);
   localparam logic [IDX_W-1:0] IDX_OBJ = IDX_W'(NUM_BOX);
   localparam logic [IDX_W-1:0] IDX_END = IDX_W'(FIRST_CLASS + MAX_CLASSES);

   function automatic logic signed [31:0] sat_score(input logic signed [63:0] p);
      logic signed [47:0] q;
      logic signed [31:0] r;
      q = p[63:16];   // shift right by 16 rounding down
      if (q > 48'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (q < -48'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = q[31:0];
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [16:0] conf_threshold_ff;
   logic [21:0] x_scale_ff, y_scale_ff;
   logic [14:0] frame_width_ff, frame_height_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_threshold_ff <= 17'd16384;
         x_scale_ff        <= 22'd65536;
         y_scale_ff        <= 22'd65536;
         frame_width_ff    <= 15'd640;
         frame_height_ff   <= 15'd640;
      end else if (csr_write) begin
         case (csr_index)
            REG_CONF_THRESHOLD: conf_threshold_ff <= csr_pwdata[16:0];
            REG_X_SCALE:        x_scale_ff        <= csr_pwdata[21:0];
            REG_Y_SCALE:        y_scale_ff        <= csr_pwdata[21:0];
            REG_FRAME_WIDTH:    frame_width_ff    <= csr_pwdata[14:0];
            REG_FRAME_HEIGHT:   frame_height_ff   <= csr_pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CONF_THRESHOLD: csr_prdata = {15'b0, conf_threshold_ff};
         REG_X_SCALE:        csr_prdata = {10'b0, x_scale_ff};
         REG_Y_SCALE:        csr_prdata = {10'b0, y_scale_ff};
         REG_FRAME_WIDTH:    csr_prdata = {17'b0, frame_width_ff};
         REG_FRAME_HEIGHT:   csr_prdata = {17'b0, frame_height_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Entry stage: place box and objectness, multiply class scores
   // ------------------------------------------------------------------
   logic               req_accept;
   logic               stall;
   logic [IDX_W-1:0]   idx_ff;
   logic signed [31:0] box_raw_ff [NUM_BOX];
   logic signed [31:0] objectness_ff;
   logic [IDX_W+6:0]   cls_wide;

   logic               s1_valid_ff;
   logic               s1_last_ff;
   logic               s1_is_class_ff;
   logic [6:0]         s1_class_ff;
   logic signed [63:0] s1_prod_ff;

   logic               emit_busy;
   logic               emit_load;

   assign stall      = s1_valid_ff && s1_last_ff && emit_busy;
   assign req_tready = !stall;
   assign req_accept = req_tvalid && req_tready;
   assign cls_wide   = {7'b0, idx_ff} - (IDX_W + 7)'(FIRST_CLASS);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         objectness_ff <= '0;
         for (int i = 0; i < NUM_BOX; i++) begin
            box_raw_ff[i] <= '0;
         end
      end else if (req_accept) begin
         if (idx_ff < IDX_OBJ) begin
            box_raw_ff[idx_ff[1:0]] <= $signed(req_tdata);
         end
         if (idx_ff == IDX_OBJ) begin
            objectness_ff <= $signed(req_tdata);
         end
         // Advance the column count, hold past the last class column
         if (req_tlast) begin
            idx_ff <= '0;
         end else if (idx_ff < IDX_END) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_last_ff     <= req_tlast;
         s1_is_class_ff <= (idx_ff > IDX_OBJ) && (idx_ff < IDX_END);
         s1_class_ff    <= cls_wide[6:0];
         s1_prod_ff     <= $signed(req_tdata) * objectness_ff;
      end
   end

   // ------------------------------------------------------------------
   // Ranking chain
   // ------------------------------------------------------------------
   entry_type     new_entry;
   entry_type     next_entries [TOP_K];
   cell_link_type links [TOP_K];
   cell_link_type head_link;
   logic          cell_ins;
   logic          cell_clr;
   logic [TOP_K-1:0] cell_valid;

   assign new_entry.valid    = 1'b1;
   assign new_entry.class_id = s1_class_ff;
   assign new_entry.score    = sat_score(s1_prod_ff);

   // Left of the first cell nothing ranks lower: a losing first cell takes the new entry
   assign head_link.entry = '0;
   assign head_link.beats = 1'b1;

   assign cell_ins = s1_valid_ff && s1_is_class_ff && !stall;
   assign cell_clr = s1_valid_ff && s1_last_ff && !stall;

   for (genvar g = 0; g < TOP_K; g++) begin : g_cell
      dtk_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ins        (cell_ins),
         .clr        (cell_clr),
         .new_entry  (new_entry),
         .prev_link  ((g == 0) ? head_link : links[(g == 0) ? 0 : g - 1]),
         .link_out   (links[g]),
         .next_entry (next_entries[g])
      );
      assign cell_valid[g] = links[g].entry.valid;
   end

   // Report a row whose best score beats the threshold
   assign emit_load = cell_clr && next_entries[0].valid &&
                      ($signed({next_entries[0].score[31], next_entries[0].score}) >
                       $signed({16'b0, conf_threshold_ff}));

   // ------------------------------------------------------------------
   // Result unit
   // ------------------------------------------------------------------
   result_type rsp_result;

   dtk_emit #(
      .TOP_K (TOP_K)
   ) u_emit (
      .clock        (clock),
      .reset        (reset),
      .load         (emit_load),
      .load_entries (next_entries),
      .load_raw     (box_raw_ff),
      .x_scale      (x_scale_ff),
      .y_scale      (y_scale_ff),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .busy         (emit_busy),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_last     (rsp_tlast),
      .rsp_result   (rsp_result)
   );

   assign rsp_tdata = {6'b0, rsp_result};

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `DTK_ASSERT_IMPLY(a_stall_needs_busy, !req_tready, emit_busy,
      "input stalled while result unit idle")
   `DTK_ASSERT_IMPLY(a_load_when_idle, emit_load, !emit_busy,
      "row snapshot taken while result unit busy")
   `DTK_ASSERT_NEXT(a_last_beat_drains, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid,
      "result beat follows the last beat of a row")
   `DTK_ASSERT_IMPLY(a_cells_prefix, !cell_valid[0], cell_valid == '0,
      "ranking chain holds an entry behind an empty first cell")

endmodule

// ----- tb/tb_detection_row_topk_decode.sv -----
// ----------------------------------------------------------------------------
// tb_detection_row_topk_decode
// Self-checking bench for the detection row top-k decoder: a directed table
// of rows under the reset register values, then random rows over several
// register settings and handshake idling profiles. Every result beat is
// checked field by field against the directed table or an in-bench
// prediction of the ranking and box decode.
// ----------------------------------------------------------------------------
module tb_detection_row_topk_decode;
   timeunit 1ns;
   timeprecision 1ps;

   import dtk_pkg::*;

   localparam int TOP_K           = 5;
   localparam int MAX_CLASSES     = 128;
   localparam int SETTLE_CYCLES   = 24;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT     = 4000;
   localparam int PHASE_ITEMS     = 36;
   localparam int NUM_PHASES      = 6;
   localparam int NUM_DIRECTED    = 28;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // One ranked detection as it leaves the block
   typedef struct {
      result_type beat;
      logic       last;
   } det_type;

   // Directed row element; typed_count < 0 leaves the check to the prediction
   typedef struct {
      logic [31:0] value;
      logic        row_end;
      int          typed_count;
      int          cls;
      longint      score;
      int          left;
      int          top;
      int          width;
      int          height;
   } dir_elem_type;

   // Register setting of one random phase; a negative threshold means random
   typedef struct {
      int            thr;
      int            xs;
      int            ys;
      int            fw;
      int            fh;
      idle_mode_type mode;
   } phase_cfg_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata = '0;     // [31:0] element_value
   logic          req_tlast = 1'b0;   // row_end
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b1;
   logic [111:0]  rsp_tdata;          // [2:0] rank, [9:3] class_id, [41:10] class_score,
                                      // [57:42] box_left, [73:58] box_top,
                                      // [89:74] box_width, [105:90] box_height
   logic          rsp_tlast;          // last_of_row
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [4:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   detection_row_topk_decode #(
      .TOP_K       (TOP_K),
      .MAX_CLASSES (MAX_CLASSES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Register copies, reset values
   longint conf_thr = 16384;
   longint scale_x  = 65536;
   longint scale_y  = 65536;
   longint frame_w  = 640;
   longint frame_h  = 640;

   // Row state of the ranking prediction
   int     elem_idx = 0;
   longint box_raw [4] = '{0, 0, 0, 0};
   longint objness = 0;
   longint kept_score [TOP_K];
   int     kept_class [TOP_K];
   int     kept_count = 0;

   det_type       pending_dets[$];
   int            fail_count = 0;
   idle_mode_type cur_mode = IDLE_NONE;
   bit            pressure_on = 1'b0;
   int            hold_count = 0;
   bit            hold_done = 1'b0;
   int            quiet_cycles = 0;
   det_type       no_det;
   det_type       want_det;
   result_type    seen_beat;

   longint tie_scores [4] = '{8192, 16384, 32768, 65536};

   dir_elem_type directed_rows [NUM_DIRECTED] = '{
      // normalized box on a 640x640 frame, one class at 1.0
      '{32'h0000_8000, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0000_8000, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0000_4000, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0000_4000, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0001_0000, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0001_0000, 1'b1,  1, 0, 65536, 240, 240, 160, 160},
      // row ends inside the box: nothing reported
      '{32'h0000_0064, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0000_00c8, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0000_012c, 1'b1,  0, 0, 0, 0, 0, 0, 0},
      // row end on the very first element
      '{32'h7fff_ffff, 1'b1,  0, 0, 0, 0, 0, 0, 0},
      // extreme values: the score saturates, width and height reach the 16-bit limits
      '{32'h7fff_ffff, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h8000_0000, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h7fff_ffff, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h8000_0000, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h7fff_ffff, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h7fff_ffff, 1'b1,  1, 0, 64'h7fff_ffff, 16384, -16384, 32767, -32768},
      // one coordinate just over 1.0 picks the scale path; ties, a negative
      // score and a late class that displaces the fifth entry
      '{32'h0001_0000, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0001_0001, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0000_0000, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0000_8000, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0000_ffff, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0000_7530, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0000_7530, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0001_1170, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0000_7530, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0000_7530, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'hffff_fffb, 1'b0, -1, 0, 0, 0, 0, 0, 0},
      '{32'h0001_1171, 1'b1, -1, 0, 0, 0, 0, 0, 0}
   };

   phase_cfg_type phase_plan [NUM_PHASES] = '{
      '{0,     65536,   65536,   640,   480,   IDLE_NONE},
      '{65536, 4194303, 4194303, 16384, 16384, IDLE_SENDER},
      '{16384, 0,       0,       1,     1,     IDLE_RECEIVER},
      '{-1,    0,       0,       0,     0,     IDLE_BOTH},
      '{8000,  131072,  98304,   1920,  1080,  IDLE_NONE},
      '{-1,    0,       0,       0,     0,     IDLE_BOTH}
   };

   function automatic longint sat_to(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint trunc_shift(longint p, int sh);
      return p >= 0 ? (p >>> sh) : -((-p) >>> sh);
   endfunction

   // Insert a class score into the kept list, best first, ties after
   function automatic void rank_class(int cls, longint score);
      int n;
      int pos;
      int i;
      n = kept_count;
      pos = 0;
      if (n >= TOP_K) begin
         if (!(score > kept_score[TOP_K-1]))
            return;
         n = TOP_K - 1;
      end
      while (pos < n && kept_score[pos] >= score)
         pos++;
      for (i = n; i > pos; i--) begin
         kept_score[i] = kept_score[i-1];
         kept_class[i] = kept_class[i-1];
      end
      kept_score[pos] = score;
      kept_class[pos] = cls;
      kept_count = n + 1;
   endfunction

   // Advance the row state by one element and return the detections it emits
   function automatic void decode_element(input logic [31:0] value, input logic row_end,
                                          output det_type dets[$]);
      longint  v;
      longint  cx;
      longint  cy;
      longint  w;
      longint  h;
      longint  left;
      longint  top;
      det_type d;
      int      k;
      dets.delete();
      v = longint'($signed(value));
      if (elem_idx < 4)
         box_raw[elem_idx] = v;
      else if (elem_idx == 4)
         objness = v;
      else if (elem_idx < 5 + MAX_CLASSES)
         rank_class(elem_idx - 5, sat_to((v * objness) >>> 16, -64'sd2147483648,
                                         64'sd2147483647));
      if (elem_idx < 5 + MAX_CLASSES)
         elem_idx++;
      if (row_end) begin
         if (kept_count > 0 && kept_score[0] > conf_thr) begin
            if (box_raw[0] > 65536 || box_raw[1] > 65536 ||
                box_raw[2] > 65536 || box_raw[3] > 65536) begin
               cx = trunc_shift(box_raw[0] * scale_x, 32);
               cy = trunc_shift(box_raw[1] * scale_y, 32);
               w  = trunc_shift(box_raw[2] * scale_x, 32);
               h  = trunc_shift(box_raw[3] * scale_y, 32);
            end else begin
               cx = trunc_shift(box_raw[0] * frame_w, 16);
               cy = trunc_shift(box_raw[1] * frame_h, 16);
               w  = trunc_shift(box_raw[2] * frame_w, 16);
               h  = trunc_shift(box_raw[3] * frame_h, 16);
            end
            left = sat_to(cx - w / 2, -32768, 32767);
            top  = sat_to(cy - h / 2, -32768, 32767);
            w    = sat_to(w, -32768, 32767);
            h    = sat_to(h, -32768, 32767);
            for (k = 0; k < kept_count; k++) begin
               d.beat.rank        = k[2:0];
               d.beat.class_id    = kept_class[k][6:0];
               d.beat.class_score = kept_score[k][31:0];
               d.beat.box_left    = left[15:0];
               d.beat.box_top     = top[15:0];
               d.beat.box_width   = w[15:0];
               d.beat.box_height  = h[15:0];
               d.last             = (k + 1 == kept_count);
               dets = {dets, d};
            end
         end
         elem_idx = 0;
         kept_count = 0;
      end
   endfunction

   function automatic bit sender_idles();
      return (cur_mode == IDLE_SENDER && $urandom_range(0, 99) < 84) ||
             (cur_mode == IDLE_BOTH && $urandom_range(0, 99) < 10);
   endfunction

   function automatic bit receiver_stalls();
      return (cur_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 84) ||
             (cur_mode == IDLE_BOTH && $urandom_range(0, 99) < 10);
   endfunction

   function automatic void check_field(string name, longint want, longint seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         fail_count++;
      end
   endfunction

   // Offer one element, wait for its beat, then queue what it should produce
   task automatic send_element(logic [31:0] value, logic row_end, int typed_count,
                               det_type typed);
      det_type dets[$];
      @(negedge clock);
      while (sender_idles()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= row_end;
      do @(posedge clock); while (!req_tready);
      decode_element(value, row_end, dets);
      if (typed_count < 0)
         foreach (dets[i]) pending_dets = {pending_dets, dets[i]};
      else if (typed_count > 0)
         pending_dets = {pending_dets, typed};
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Wait out every expected beat, then the decode pipeline of rows that emit none
   task automatic drain_results();
      while (pending_dets.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write, then read back through the same port
   task automatic write_csr(logic [2:0] reg_id, logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] readback;
      case (reg_id)
         REG_CONF_THRESHOLD: mask = 32'h0001_ffff;
         REG_X_SCALE,
         REG_Y_SCALE:        mask = 32'h003f_ffff;
         default:            mask = 32'h0000_7fff;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_id, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== (value & mask)) begin
         $error("csr readback 0x%0h: expected 0x%0h, got 0x%0h", {reg_id, 2'b00},
                value & mask, readback);
         fail_count++;
      end
      case (reg_id)
         REG_CONF_THRESHOLD: conf_thr = longint'(value & mask);
         REG_X_SCALE:        scale_x  = longint'(value & mask);
         REG_Y_SCALE:        scale_y  = longint'(value & mask);
         REG_FRAME_WIDTH:    frame_w  = longint'(value & mask);
         default:            frame_h  = longint'(value & mask);
      endcase
   endtask

   // Build one random row: mostly well-formed, some short, some noise
   function automatic void make_row(input bit long_row, output logic [31:0] elems[$]);
      int          pick;
      int          n;
      int          i;
      bit          pixel;
      logic [31:0] v;
      elems.delete();
      pick = $urandom_range(0, 99);
      if (long_row) begin
         // rising scores so the last class columns win, past the class limit too
         for (i = 0; i < 4; i++) begin
            v = $urandom_range(0, 65536);
            elems = {elems, v};
         end
         elems = {elems, 32'h0001_0000};
         n = $urandom_range(126, 140);
         for (i = 0; i < n; i++) begin
            v = i * 1024 + $urandom_range(0, 1023);
            elems = {elems, v};
         end
      end else if (pick < 16) begin
         n = (pick < 8) ? $urandom_range(1, 5) : $urandom_range(6, 14);
         for (i = 0; i < n; i++) begin
            v = $urandom;
            elems = {elems, v};
         end
      end else begin
         pixel = ($urandom_range(0, 1) != 0);
         for (i = 0; i < 4; i++) begin
            v = pixel ? $urandom_range(65537, 700 * 65536) : $urandom_range(0, 65536);
            if ($urandom_range(0, 15) == 0)
               v = -v;
            elems = {elems, v};
         end
         v = $urandom_range(0, 65536);
         if ($urandom_range(0, 15) == 0)
            v = $urandom;
         elems = {elems, v};
         n = $urandom_range(1, 12);
         for (i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
               v = 32'(tie_scores[$urandom_range(0, 3)]);
            else if (pick < 35)
               v = $urandom;
            else
               v = $urandom_range(0, 131072);
            elems = {elems, v};
         end
      end
   endfunction

   // Result side ready: one long hold-off under pressure, else per idling profile
   always @(negedge clock) begin
      if (pressure_on && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_count++;
         if (hold_count == HOLD_OFF_CYCLES)
            hold_done = 1'b1;
      end else begin
         rsp_tready <= !receiver_stalls();
      end
   end

   // Compare each result beat with the oldest expected detection
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_dets.size() == 0) begin
            $error("result beat with no detection expected");
            fail_count++;
         end else begin
            want_det  = pending_dets.pop_front();
            seen_beat = rsp_tdata[$bits(result_type)-1:0];
            check_field("rank", want_det.beat.rank, seen_beat.rank);
            check_field("class_id", want_det.beat.class_id, seen_beat.class_id);
            check_field("class_score", want_det.beat.class_score, seen_beat.class_score);
            check_field("box_left", want_det.beat.box_left, seen_beat.box_left);
            check_field("box_top", want_det.beat.box_top, seen_beat.box_top);
            check_field("box_width", want_det.beat.box_width, seen_beat.box_width);
            check_field("box_height", want_det.beat.box_height, seen_beat.box_height);
            check_field("last_of_row", want_det.last, rsp_tlast);
         end
      end
   end

   // Watchdog: end the run after too many cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("detection_row_topk_decode verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      det_type       typed;
      logic [31:0]   elems[$];
      phase_cfg_type cfg;
      int            sent;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows under the reset register values
      foreach (directed_rows[r]) begin
         typed.beat.rank        = '0;
         typed.beat.class_id    = directed_rows[r].cls[6:0];
         typed.beat.class_score = directed_rows[r].score[31:0];
         typed.beat.box_left    = directed_rows[r].left[15:0];
         typed.beat.box_top     = directed_rows[r].top[15:0];
         typed.beat.box_width   = directed_rows[r].width[15:0];
         typed.beat.box_height  = directed_rows[r].height[15:0];
         typed.last             = 1'b1;
         send_element(directed_rows[r].value, directed_rows[r].row_end,
                      directed_rows[r].typed_count, typed);
      end
      stop_sending();
      drain_results();

      // Random rows, one register setting and idling profile per phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         cfg = phase_plan[p];
         if (cfg.thr < 0) begin
            cfg.thr = $urandom_range(0, 65536);
            cfg.xs  = $urandom_range(0, 4194303);
            cfg.ys  = $urandom_range(0, 4194303);
            cfg.fw  = $urandom_range(1, 16384);
            cfg.fh  = $urandom_range(1, 16384);
         end
         write_csr(REG_CONF_THRESHOLD, cfg.thr);
         write_csr(REG_X_SCALE, cfg.xs);
         write_csr(REG_Y_SCALE, cfg.ys);
         write_csr(REG_FRAME_WIDTH, cfg.fw);
         write_csr(REG_FRAME_HEIGHT, cfg.fh);
         cur_mode = cfg.mode;
         pressure_on = (cfg.mode == IDLE_RECEIVER);
         sent = 0;
         if (p == 1) begin
            make_row(1'b1, elems);
            foreach (elems[k])
               send_element(elems[k], k == elems.size() - 1, -1, no_det);
         end
         while (sent < PHASE_ITEMS) begin
            make_row(1'b0, elems);
            foreach (elems[k])
               send_element(elems[k], k == elems.size() - 1, -1, no_det);
            sent += elems.size();
         end
         stop_sending();
         drain_results();
         pressure_on = 1'b0;
         cur_mode = IDLE_NONE;
      end

      if (fail_count == 0 && pending_dets.size() == 0)
         $display("detection_row_topk_decode verification clean");
      else
         $display("detection_row_topk_decode verification failed");
      $finish;
   end

endmodule
